// ===== sv/lru_k_frame_replacer_unit_defines.svh =====
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef LRU_K_FRAME_REPLACER_UNIT_DEFINES_SVH
`define LRU_K_FRAME_REPLACER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LKFR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkfr check failed");

// next-cycle implication, disabled during reset
`define LKFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkfr check failed");

`endif

// ===== sv/lkfr_pkg.sv =====
// ---------------------------------------------------------------------------
// lkfr_pkg
// shared types, codes and defaults of the lru-k frame replacer
// ---------------------------------------------------------------------------
package lkfr_pkg;

  localparam int FRAMES_DEF     = 64;
  localparam int MAX_K_DEF      = 4;
  localparam int STAMP_BITS_DEF = 32;

  localparam int IDX_W      = 6;
  localparam int COUNT_W    = 7;
  localparam int DEPTH_W    = 3;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 3'd2;

  typedef enum logic [1:0] {
    CMD_ACCESS     = 2'd0,
    CMD_SET_EVICT  = 2'd1,
    CMD_REMOVE     = 2'd2,
    CMD_EVICT      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_RANGE  = 2'd2,
    ST_PINNED = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e              command;
    logic [IDX_W-1:0]  frame_index;
    logic              mark_evictable;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [IDX_W-1:0]    victim_frame;
    logic [COUNT_W-1:0]  evictable_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic flag_op;
    logic meta_read;
    logic acc_write;
    logic scan_issue;
    logic commit;
    logic out_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e command;
    logic idx_ok;
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/lkfr_ctrl.sv =====
// ---------------------------------------------------------------------------
// lkfr_ctrl
// command sequencer: decode, access update, evict scan and result hand-off
// ---------------------------------------------------------------------------
module lkfr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lkfr_pkg::dp_stat_t stat,
  output lkfr_pkg::ctl_cmd_t ctl
);
  import lkfr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_ACC_WR = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.command == CMD_EVICT) begin
          state_next = S_SCAN;
        end else if (stat.command == CMD_ACCESS && stat.idx_ok) begin
          ctl.meta_read = 1'b1;
          state_next    = S_ACC_WR;
        end else begin
          ctl.flag_op = 1'b1;
          state_next  = S_RESULT;
        end
      end
      S_ACC_WR: begin
        ctl.acc_write = 1'b1;
        state_next    = S_RESULT;
      end
      S_SCAN: begin
        ctl.scan_issue = 1'b1;
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ===== sv/lkfr_datapath.sv =====
// ---------------------------------------------------------------------------
// lkfr_datapath
// frame flags, stamp and ring memories, scan pipeline and result register
// ---------------------------------------------------------------------------
module lkfr_datapath #(
  parameter int FRAMES     = lkfr_pkg::FRAMES_DEF,
  parameter int MAX_K      = lkfr_pkg::MAX_K_DEF,
  parameter int STAMP_BITS = lkfr_pkg::STAMP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lkfr_pkg::in_item_t                in_data,
  input  logic                              out_stall,
  output logic                              out_valid,
  output lkfr_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [lkfr_pkg::DEPTH_W-1:0]      cfg_data,
  input  lkfr_pkg::ctl_cmd_t                ctl,
  output lkfr_pkg::dp_stat_t                stat
);
  import lkfr_pkg::*;

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(MAX_K + 1);
  localparam int SW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int AW = (FRAMES * MAX_K > 1) ? $clog2(FRAMES * MAX_K) : 1;
  localparam int TW = $clog2(FRAMES + 1);
  localparam int RW = CW + 1;
  localparam int MW = CW + SW;
  localparam logic [AW-1:0] K_ADDR = AW'(MAX_K);
  localparam logic [RW-1:0] K_RING = RW'(MAX_K);
  localparam logic [CW-1:0] K_CNT  = CW'(MAX_K);

  // configuration
  logic [DEPTH_W-1:0] depth;
  logic [CW-1:0]      k_eff;

  always_ff @(posedge clk) begin
    if (rst)         depth <= DEPTH_RESET;
    else if (cfg_we) depth <= cfg_data;
  end

  always_comb begin
    if (depth == '0)                       k_eff = CW'(1);
    else if (32'(depth) > 32'(MAX_K))      k_eff = K_CNT;
    else                                   k_eff = CW'(depth);
  end

  // captured command
  cmd_e             cur_cmd;
  logic [IDX_W-1:0] cur_idx;
  logic             cur_mark;
  logic [FW-1:0]    cur_f;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cur_cmd  <= in_data.command;
      cur_idx  <= in_data.frame_index;
      cur_mark <= in_data.mark_evictable;
    end
  end

  assign cur_f = FW'(cur_idx);

  // tracked and evictable flags, evictable total, access clock
  logic [FRAMES-1:0]     present, evict;
  logic [TW-1:0]         total;
  logic [STAMP_BITS-1:0] clock_q;

  // ring metadata {count, write slot}, valid only while the frame is present
  logic [MW-1:0]          meta_mem [FRAMES];
  logic [MW-1:0]          meta_q;
  logic [FW-1:0]          meta_raddr;
  logic [STAMP_BITS-1:0]  stamp_mem [FRAMES*MAX_K];
  logic [STAMP_BITS-1:0]  stamp_q;
  logic [AW-1:0]          stamp_addr;

  // scan pipeline
  logic [FW-1:0]          scan_idx;
  logic                   p1_valid, p2_valid;
  logic [FW-1:0]          p1_idx, p2_idx;
  logic                   p1_el, p2_el, p2_inf;
  logic                   best_found, best_inf;
  logic [STAMP_BITS-1:0]  best_stamp;
  logic [FW-1:0]          best_idx;

  // result
  status_e                res_status;
  logic [IDX_W-1:0]       res_victim;

  // access update values
  logic [CW-1:0] acc_cnt, acc_cnt_next;
  logic [SW-1:0] acc_slot, acc_slot_next;

  always_comb begin
    acc_cnt  = present[cur_f] ? meta_q[MW-1:SW] : '0;
    acc_slot = present[cur_f] ? meta_q[SW-1:0]  : '0;
    acc_cnt_next = (acc_cnt < K_CNT) ? acc_cnt + CW'(1) : acc_cnt;
    if (32'(acc_slot) + 32'd1 >= 32'(MAX_K)) acc_slot_next = '0;
    else                                     acc_slot_next = acc_slot + SW'(1);
  end

  // reference slot of the frame in stage one
  logic [CW-1:0] s1_cnt, s1_n;
  logic [RW-1:0] s1_sum;
  logic [SW-1:0] s1_slot;
  logic          s1_inf;

  always_comb begin
    s1_cnt = meta_q[MW-1:SW];
    s1_inf = s1_cnt < k_eff;
    s1_n   = s1_inf ? s1_cnt : k_eff;
    s1_sum = RW'(meta_q[SW-1:0]) + K_RING - RW'(s1_n);
    if (s1_sum >= K_RING) s1_sum = s1_sum - K_RING;
    s1_slot = SW'(s1_sum);
  end

  // memory addresses
  assign meta_raddr = ctl.scan_issue ? scan_idx : cur_f;
  always_comb begin
    if (ctl.acc_write) stamp_addr = AW'(cur_f) * K_ADDR + AW'(acc_slot);
    else               stamp_addr = AW'(p1_idx) * K_ADDR + AW'(s1_slot);
  end

  // memories
  always_ff @(posedge clk) begin
    meta_q  <= meta_mem[meta_raddr];
    stamp_q <= stamp_mem[stamp_addr];
    if (ctl.acc_write) begin
      meta_mem[cur_f]       <= {acc_cnt_next, acc_slot_next};
      stamp_mem[stamp_addr] <= clock_q;
    end
  end

  // scan stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= ctl.scan_issue;
      p2_valid <= p1_valid;
    end
    p1_idx <= scan_idx;
    p1_el  <= present[scan_idx] & evict[scan_idx];
    p2_idx <= p1_idx;
    p2_el  <= p1_el;
    p2_inf <= s1_inf;
  end

  // running best and scan index
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      scan_idx   <= '0;
      best_found <= 1'b0;
    end else begin
      if (ctl.scan_issue) scan_idx <= scan_idx + FW'(1);
      if (p2_valid && p2_el &&
          (!best_found || (p2_inf && !best_inf) ||
           (p2_inf == best_inf && stamp_q < best_stamp))) begin
        best_found <= 1'b1;
        best_inf   <= p2_inf;
        best_stamp <= stamp_q;
        best_idx   <= p2_idx;
      end
    end
  end

  // flags, total and clock
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      evict   <= '0;
      total   <= '0;
      clock_q <= '0;
    end else begin
      if (ctl.acc_write) begin
        present[cur_f] <= 1'b1;
        if (clock_q != '1) clock_q <= clock_q + STAMP_BITS'(1);
      end
      if (ctl.flag_op && stat.idx_ok && present[cur_f]) begin
        if (cur_cmd == CMD_SET_EVICT) begin
          if (!evict[cur_f] && cur_mark)      total <= total + TW'(1);
          else if (evict[cur_f] && !cur_mark) total <= total - TW'(1);
          evict[cur_f] <= cur_mark;
        end else if (cur_cmd == CMD_REMOVE && evict[cur_f]) begin
          present[cur_f] <= 1'b0;
          evict[cur_f]   <= 1'b0;
          total          <= total - TW'(1);
        end
      end
      if (ctl.commit && best_found) begin
        present[best_idx] <= 1'b0;
        evict[best_idx]   <= 1'b0;
        total             <= total - TW'(1);
      end
    end
  end

  // result of the current command
  always_ff @(posedge clk) begin
    if (ctl.acc_write) begin
      res_status <= ST_OK;
      res_victim <= '0;
    end else if (ctl.flag_op) begin
      res_victim <= '0;
      if (!stat.idx_ok)
        res_status <= ST_RANGE;
      else if (cur_cmd == CMD_REMOVE && present[cur_f] && !evict[cur_f])
        res_status <= ST_PINNED;
      else
        res_status <= ST_OK;
    end else if (ctl.commit) begin
      res_status <= best_found ? ST_OK : ST_EMPTY;
      res_victim <= best_found ? IDX_W'(best_idx) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (ctl.out_load) begin
      out_data.status          <= res_status;
      out_data.victim_frame    <= res_victim;
      out_data.evictable_count <= COUNT_W'(total);
    end
  end

  // status to controller
  assign stat.command   = cur_cmd;
  assign stat.idx_ok    = (32'(cur_idx) < 32'(FRAMES));
  assign stat.scan_last = (scan_idx == FW'(FRAMES - 1));
  assign stat.pipe_busy = p1_valid | p2_valid;
  assign stat.out_free  = !out_valid | !out_stall;

endmodule

// ===== sv/lru_k_frame_replacer_unit.sv =====
// ---------------------------------------------------------------------------
// lru_k_frame_replacer_unit
// lru-k victim selector over a fixed set of frames
// ---------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_data) takes one command per beat:
//   access, set evictable, remove or evict. out channel returns exactly one
//   result beat per command: status, victim frame and evictable count.
//   cfg_we/cfg_data write k (history depth); write only while idle.
// Timing:
//   one command in flight at a time. the evict scan reads each frame's ring
//   metadata and one stamp through the single read port of each memory, one
//   frame per cycle.
// Reset:
//   rst (synchronous) clears all frame flags, the evictable total, the
//   access clock and sets k to 2; stamp memories need no clearing pass.
// Stall:
//   the result register holds while out_stall is high; a new command is
//   taken meanwhile and its result waits until the register frees.
// ---------------------------------------------------------------------------
module lru_k_frame_replacer_unit #(
  parameter int FRAMES     = lkfr_pkg::FRAMES_DEF,
  parameter int MAX_K      = lkfr_pkg::MAX_K_DEF,
  parameter int STAMP_BITS = lkfr_pkg::STAMP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lkfr_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lkfr_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [lkfr_pkg::DEPTH_W-1:0] cfg_data
);
  import lkfr_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // sequencer
  lkfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // storage and scan
  lkfr_datapath #(
    .FRAMES     (FRAMES),
    .MAX_K      (MAX_K),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule

// ===== sv/lkfr_checker.sv =====
// ---------------------------------------------------------------------------
// lkfr_checker
// port-level checks of the lru-k frame replacer
// ---------------------------------------------------------------------------
`include "lru_k_frame_replacer_unit_defines.svh"

module lkfr_checker #(
  parameter int FRAMES = lkfr_pkg::FRAMES_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lkfr_pkg::out_item_t out_data
);
  import lkfr_pkg::*;

  // stalled result beat stays
  `LKFR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // stalled result beat keeps its payload
  `LKFR_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_data))

  // victim is zero unless an ok result
  `LKFR_ASSERT_NOW(a_victim_zero, clk, rst, out_valid && out_data.status != ST_OK, out_data.victim_frame == '0)

  // an accepted command blocks the next beat
  `LKFR_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall)

endmodule

bind lru_k_frame_replacer_unit lkfr_checker #(.FRAMES(FRAMES)) u_lkfr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// checks the lru-k frame replacer against an in-bench model of frame history,
// evictable flags and victim selection, under random idling on both sides
// ---------------------------------------------------------------------------
module tb;
  import lkfr_pkg::*;

  class replacer_scoreboard;
    bit           present [64];
    bit           evictable [64];
    bit [31:0]    stamps [64][4];
    int unsigned  stamp_cnt [64];
    int unsigned  next_slot [64];
    bit [31:0]    clock_now;
    int unsigned  evict_total;
    bit [2:0]     depth;
    out_item_t    pending [$];
    int           errors;

    function void reset_state();
      for (int f = 0; f < 64; f++) begin
        present[f] = 0;
        evictable[f] = 0;
        stamp_cnt[f] = 0;
        next_slot[f] = 0;
      end
      clock_now = 0;
      evict_total = 0;
      depth = DEPTH_RESET;
      pending.delete();
      errors = 0;
    endfunction

    function void drop_frame(int f);
      present[f] = 0;
      evictable[f] = 0;
      stamp_cnt[f] = 0;
      next_slot[f] = 0;
    endfunction

    // work out the result of one accepted command
    function void note_command(in_item_t it);
      out_item_t r;
      int unsigned k, n, f, best;
      bit found, best_inf, inf;
      bit [31:0] best_stamp, s;
      r.status = ST_OK;
      r.victim_frame = '0;
      f = it.frame_index;
      k = (depth == 0) ? 1 : (depth > 4) ? 4 : depth;
      case (it.command)
        CMD_ACCESS: begin
          if (!present[f]) begin
            drop_frame(f);
            present[f] = 1;
          end
          stamps[f][next_slot[f]] = clock_now;
          next_slot[f] = (next_slot[f] + 1) % 4;
          if (stamp_cnt[f] < 4) stamp_cnt[f]++;
          if (clock_now != 32'hFFFF_FFFF) clock_now++;
        end
        CMD_SET_EVICT: begin
          if (present[f]) begin
            if (!evictable[f] && it.mark_evictable) evict_total++;
            else if (evictable[f] && !it.mark_evictable) evict_total--;
            evictable[f] = it.mark_evictable;
          end
        end
        CMD_REMOVE: begin
          if (present[f]) begin
            if (!evictable[f]) r.status = ST_PINNED;
            else begin
              drop_frame(f);
              evict_total--;
            end
          end
        end
        default: begin
          found = 0; best_inf = 0; best_stamp = 0; best = 0;
          for (int g = 0; g < 64; g++) begin
            if (!present[g] || !evictable[g]) continue;
            inf = stamp_cnt[g] < k;
            n = (stamp_cnt[g] < k) ? stamp_cnt[g] : k;
            s = stamps[g][(next_slot[g] + 4 - n) % 4];
            if (!found || (inf && !best_inf) || (inf == best_inf && s < best_stamp)) begin
              found = 1; best_inf = inf; best_stamp = s; best = g;
            end
          end
          if (found) begin
            drop_frame(best);
            evict_total--;
            r.victim_frame = best[5:0];
          end else r.status = ST_EMPTY;
        end
      endcase
      r.evictable_count = evict_total[6:0];
      pending.push_back(r);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(out_item_t got, longint t);
      out_item_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", t, got);
        errors++;
        return;
      end
      w = pending[0];
      pending.delete(0);
      if (got.status !== w.status)
        $display("%0t: status expected %0d actual %0d", t, w.status, got.status);
      if (got.victim_frame !== w.victim_frame)
        $display("%0t: victim expected %0d actual %0d", t, w.victim_frame, got.victim_frame);
      if (got.evictable_count !== w.evictable_count)
        $display("%0t: count expected %0d actual %0d", t, w.evictable_count,
                 got.evictable_count);
      if (got !== w) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic [DEPTH_W-1:0] cfg_data = '0;

  replacer_scoreboard board = new();
  longint cycles = 0;
  bit calm = 0;

  lru_k_frame_replacer_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // limit on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: sample accepted beats, draw stalls
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_data, $time);
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (calm) out_stall <= 0;
      else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
          out_stall <= 1;
          repeat (gap) @(posedge clk);
        end
        out_stall <= 0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  // one beat on the command channel; valid stays up until the next call
  task automatic send(cmd_e c, int f, bit m);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{command: c, frame_index: f[5:0], mark_evictable: m};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(in_data);
  endtask

  // write k once everything has drained
  task automatic set_depth(logic [2:0] d);
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    board.depth = d;
  endtask

  task automatic random_phase(int count, int hot);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send(CMD_ACCESS, $urandom_range(0, hot), 0);
      else if (r < 70) send(CMD_SET_EVICT, $urandom_range(0, hot), $urandom_range(0, 3) != 0);
      else if (r < 80) send(CMD_REMOVE, $urandom_range(0, hot), 0);
      else send(CMD_EVICT, $urandom_range(0, 63), $urandom_range(0, 1));
    end
  endtask

  initial begin
    logic [2:0] depths [6] = '{3'd0, 3'd1, 3'd4, 3'd7, 3'd3, 3'd2};
    board.reset_state();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty evict, absent frames, pinned remove, field extremes
    send(CMD_EVICT, 63, 1);
    send(CMD_SET_EVICT, 0, 1);
    send(CMD_REMOVE, 63, 0);
    send(CMD_ACCESS, 0, 1);
    send(CMD_ACCESS, 63, 0);
    send(CMD_ACCESS, 0, 0);
    send(CMD_ACCESS, 5, 0);
    send(CMD_REMOVE, 5, 0);
    send(CMD_SET_EVICT, 5, 1);
    send(CMD_SET_EVICT, 63, 1);
    send(CMD_SET_EVICT, 0, 1);
    send(CMD_SET_EVICT, 0, 1);
    send(CMD_EVICT, 0, 0);
    send(CMD_REMOVE, 5, 1);
    send(CMD_SET_EVICT, 0, 0);
    send(CMD_SET_EVICT, 0, 1);
    send(CMD_EVICT, 42, 0);
    send(CMD_EVICT, 21, 1);

    // random phases over several depths, both narrow and full index spread
    for (int p = 0; p < 6; p++) begin
      set_depth(depths[p]);
      random_phase(140, 7);
      random_phase(130, 63);
    end
    calm = 1;
    random_phase(30, 3);
    in_valid <= 0;
    calm = 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/lkfr_pkg.sv
sv/lkfr_ctrl.sv
sv/lkfr_datapath.sv
sv/lru_k_frame_replacer_unit.sv
sv/lkfr_checker.sv
tb/tb.sv
